### sv/rwle_pkg.sv
// ----------------------------------------------------------------------------
// rwle_pkg
// Shared types and constants of the register write log encoder.
// ----------------------------------------------------------------------------
package rwle_pkg;

  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned Q_DEPTH    = 9;
  localparam int unsigned APP_BYTES  = 6;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [7:0] BYTE_WAIT1   = 8'hF1;
  localparam logic [7:0] BYTE_WAIT8   = 8'hF2;
  localparam logic [7:0] BYTE_WAIT16  = 8'hF3;
  localparam logic [7:0] BYTE_END     = 8'hFF;
  localparam logic [7:0] BYTE_LOW_CMD = 8'hF0;

  localparam logic [9:0]  ADDR_SAMPLE  = 10'h200;
  localparam logic [9:0]  ADDR_MID     = 10'h0A0;
  localparam logic [3:0]  LO_DROP_LOW  = 4'd10;
  localparam logic [3:0]  LO_DROP_MID0 = 4'd0;
  localparam logic [3:0]  LO_DROP_MID2 = 4'd2;
  localparam logic [3:0]  LO_DROP_MID4 = 4'd4;
  localparam logic [3:0]  LO_BYTE_ONE  = 4'd8;
  localparam logic [3:0]  BOOK_HIT     = 4'h2;
  localparam logic [3:0]  BOOK_LIT     = 4'h0;
  localparam logic [15:0] WAIT_SAT     = 16'd32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_EMIT
  } state_t;

  typedef enum logic {
    B_IDLE,
    B_SCAN
  } book_state_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [7:0] index;
  } book_res_t;

  typedef struct packed {
    logic                   en;
    logic [2:0]             n;
    logic [8*APP_BYTES-1:0] data;
  } q_app_t;

endpackage

### sv/rwle_book.sv
// ----------------------------------------------------------------------------
// rwle_book
// Sample book: a memory of (location, length) pairs, scanned one entry per
// cycle, with insertion on a miss while space remains.
// ----------------------------------------------------------------------------
module rwle_book
  import rwle_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [23:0] loc,
  input  logic [15:0] len,
  output book_res_t   res
);

  localparam int unsigned AW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BOOK_DEPTH + 1);

  logic [39:0]   mem [BOOK_DEPTH];
  logic [39:0]   rd_data;
  logic          rd_en;
  logic          wr_en;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic          rd_valid;
  logic [AW-1:0] rd_idx;
  book_state_t   state;
  logic          match;
  logic          scan_end;

  assign match    = rd_valid && (rd_data == {loc, len});
  assign scan_end = (state == B_SCAN) && !match && (ptr == count);
  assign rd_en    = (state == B_SCAN) && !match && (ptr != count);
  assign wr_en    = scan_end && (count != CW'(BOOK_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= {loc, len};
    end
    if (rd_en) begin
      rd_data <= mem[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      count    <= '0;
      ptr      <= '0;
      rd_valid <= 1'b0;
      res      <= '0;
    end else begin
      res.done <= 1'b0;
      rd_valid <= rd_en;
      if (rd_en) begin
        rd_idx <= ptr[AW-1:0];
        ptr    <= ptr + 1'b1;
      end
      case (state)
        B_IDLE: begin
          if (start) begin
            state <= B_SCAN;
            ptr   <= '0;
          end
        end
        B_SCAN: begin
          if (match) begin
            state     <= B_IDLE;
            res.done  <= 1'b1;
            res.found <= 1'b1;
            res.index <= 8'(rd_idx);
          end else if (scan_end) begin
            state     <= B_IDLE;
            res.done  <= 1'b1;
            res.found <= wr_en;
            res.index <= 8'(count);
            if (wr_en) begin
              count <= count + 1'b1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(BOOK_DEPTH))
    else $error("book count beyond depth");

  a_done_from_scan: assert property (@(posedge clk) disable iff (rst)
    res.done |-> $past(state == B_SCAN))
    else $error("book result without a scan");

  a_index_valid: assert property (@(posedge clk) disable iff (rst)
    (res.done && res.found) |-> (CW'(res.index) < count))
    else $error("book index outside filled entries");

endmodule

### sv/rwle_queue.sv
// ----------------------------------------------------------------------------
// rwle_queue
// Byte list of one item and the output register of the master side.
// ----------------------------------------------------------------------------
module rwle_queue
  import rwle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_app_t     app,
  input  logic       drain,
  output logic       empty,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // out_byte
  output logic       m_tlast
);

  logic [7:0] q [Q_DEPTH];
  logic [3:0] cnt;
  logic       out_free;
  logic       pop;

  assign empty    = (cnt == '0);
  assign out_free = !m_tvalid || m_tready;
  assign pop      = drain && !empty && out_free;

  always_ff @(posedge clk) begin
    logic [3:0] off;
    if (pop) begin
      for (int k = 0; k < Q_DEPTH - 1; k++) begin
        q[k] <= q[k + 1];
      end
      m_tdata <= q[0];
      m_tlast <= (cnt == 4'd1);
    end else if (app.en) begin
      for (int k = 0; k < Q_DEPTH; k++) begin
        off = 4'(k) - cnt;
        if ((4'(k) >= cnt) && (off < {1'b0, app.n})) begin
          q[k] <= app.data[{off[2:0], 3'b000} +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        cnt      <= cnt - 1'b1;
        m_tvalid <= 1'b1;
      end else begin
        if (m_tready) begin
          m_tvalid <= 1'b0;
        end
        if (app.en) begin
          cnt <= cnt + 4'(app.n);
        end
      end
    end
  end

endmodule

### sv/register_write_log_encoder.sv
// ----------------------------------------------------------------------------
// register_write_log_encoder
// Turns a log of sound chip register writes into a byte command stream.
// ----------------------------------------------------------------------------
// Slave side: one item per handshake, tuser carries the command (tick, write,
// end), tdata the register address and value. Master side: one command byte
// per handshake, tlast marks the final byte caused by an item.
// Ticks are absorbed in the idle state and produce no bytes. A write or end item
// first queues the pending wait, then its own bytes, then drains the queue.
// Ordinary writes and end go from decode straight to emit.
// A length write scans the sample book memory one entry per cycle in the
// search state before its own bytes are queued and drained.
// The slave side is ready only between items; a new item may be taken while
// the final byte of the previous one still waits in the output register.
// A stalled receiver holds the output register and halts draining.
// Reset clears the pending wait, the location and the book fill count; the
// book memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module register_write_log_encoder
  import rwle_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_TDATA_W-1:0] s_tdata,  // reg_addr, reg_value, zero pad
  input  logic [1:0]            s_tuser,  // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,  // out_byte
  output logic                  m_tlast
);

  state_t      state;
  state_t      state_next;
  logic [15:0] pending_ticks;
  logic [23:0] current_location;
  logic [1:0]  cmd;
  logic [9:0]  addr;
  logic [23:0] val;
  logic        accept;
  logic        book_start;
  logic        q_empty;
  logic        drain;
  q_app_t      app;
  q_app_t      wait_app;
  book_res_t   book_res;
  logic [15:0] wait_m1;
  logic [3:0]  lo4;
  logic [7:0]  mid_byte;

  assign accept   = s_tvalid && s_tready;
  assign wait_m1  = pending_ticks - 1'b1;
  assign lo4      = addr[3:0];
  assign mid_byte = 8'(addr - ADDR_MID);

  always_comb begin
    wait_app = '0;
    if (pending_ticks == 16'd1) begin
      wait_app.n            = 3'd1;
      wait_app.data[7:0]    = BYTE_WAIT1;
    end else if (pending_ticks >= 16'd2 && pending_ticks < 16'd256) begin
      wait_app.n            = 3'd2;
      wait_app.data[15:0]   = {wait_m1[7:0], BYTE_WAIT8};
    end else if (pending_ticks >= 16'd256 && pending_ticks < WAIT_SAT) begin
      wait_app.n            = 3'd3;
      wait_app.data[23:0]   = {wait_m1[7:0], wait_m1[15:8], BYTE_WAIT16};
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    book_start = 1'b0;
    drain      = 1'b0;
    app        = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept && (s_tuser == CMD_WRITE || s_tuser == CMD_END)) begin
          app        = wait_app;
          app.en     = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_EMIT;
        if (cmd == CMD_END) begin
          app.en        = 1'b1;
          app.n         = 3'd1;
          app.data[7:0] = BYTE_END;
        end else if (addr >= ADDR_SAMPLE) begin
          if (addr[2]) begin
            book_start = 1'b1;
            state_next = ST_SEARCH;
          end
        end else if (addr < ADDR_MID) begin
          if (lo4 != LO_DROP_LOW) begin
            app.en         = 1'b1;
            app.n          = 3'd3;
            app.data[23:0] = {val[7:0], val[15:8], BYTE_LOW_CMD | {4'd0, lo4}};
          end
        end else if (!(lo4 inside {LO_DROP_MID0, LO_DROP_MID2, LO_DROP_MID4})) begin
          app.en = 1'b1;
          if (lo4 == LO_BYTE_ONE) begin
            app.n          = 3'd2;
            app.data[15:0] = {val[7:0], mid_byte};
          end else begin
            app.n          = 3'd3;
            app.data[23:0] = {val[7:0], val[15:8], mid_byte};
          end
        end
      end
      ST_SEARCH: begin
        if (book_res.done) begin
          app.en     = 1'b1;
          state_next = ST_EMIT;
          if (book_res.found) begin
            app.n          = 3'd2;
            app.data[15:0] = {book_res.index, 2'b00, addr[1:0], BOOK_HIT};
          end else begin
            app.n    = 3'd6;
            app.data = {val[7:0], val[15:8], current_location[7:0],
                        current_location[15:8], current_location[23:16],
                        2'b00, addr[1:0], BOOK_LIT};
          end
        end
      end
      ST_EMIT: begin
        drain = 1'b1;
        if (q_empty) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= s_tuser;
      addr <= s_tdata[9:0];
      val  <= s_tdata[33:10];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_ticks    <= '0;
      current_location <= '0;
    end else begin
      if (accept && s_tuser == CMD_TICK) begin
        if (pending_ticks < WAIT_SAT) begin
          pending_ticks <= pending_ticks + 1'b1;
        end
      end else if (accept && (s_tuser == CMD_WRITE || s_tuser == CMD_END)) begin
        pending_ticks <= '0;
      end
      if (state == ST_DECODE && cmd == CMD_WRITE && addr >= ADDR_SAMPLE && !addr[2]) begin
        current_location <= val;
      end
    end
  end

  rwle_book #(
    .BOOK_DEPTH(BOOK_DEPTH)
  ) u_book (
    .clk  (clk),
    .rst  (rst),
    .start(book_start),
    .loc  (current_location),
    .len  (val[15:0]),
    .res  (book_res)
  );

  rwle_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .app     (app),
    .drain   (drain),
    .empty   (q_empty),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  a_wait_sat: assert property (@(posedge clk) disable iff (rst)
    pending_ticks <= WAIT_SAT)
    else $error("pending wait beyond saturation");

  a_wait_flushed: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECODE) |-> (pending_ticks == '0))
    else $error("wait not cleared on flush");

  a_no_append_drain: assert property (@(posedge clk) disable iff (rst)
    app.en |-> !drain)
    else $error("append while draining");

endmodule

### verif/register_write_log_encoder_tb.sv
// ----------------------------------------------------------------------------
// register_write_log_encoder_tb
// Drives tick, write and end items into the encoder and predicts the command
// byte stream that each one causes: wait commands, book index and literal
// forms, range commands and dropped writes. Each byte leaving the block is
// checked against the oldest predicted byte. Directed cases come first, then
// random mixes under several idle and stall patterns, a long receiver
// hold-off and a pass that fills the sample book to its end.
// ----------------------------------------------------------------------------
module register_write_log_encoder_tb;
  import rwle_pkg::*;

  localparam int          LOG_BOOK_DEPTH = 256;
  localparam int          CYCLE_LIMIT    = 2000000;
  localparam int          MAX_REPORTS    = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cmd_byte_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA_W-1:0] s_tdata  = '0;  // reg_addr, reg_value, zero pad
  logic [1:0]            s_tuser  = CMD_TICK;  // cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;  // out_byte
  logic                  m_tlast;

  cmd_byte_t   stream_bytes[$];
  cmd_byte_t   oldest_byte;
  logic [7:0]  item_bytes[$];
  logic [15:0] ticks_owed  = '0;
  logic [23:0] sample_addr = '0;
  logic [23:0] book_addr[LOG_BOOK_DEPTH];
  logic [15:0] book_size[LOG_BOOK_DEPTH];
  int          book_fill      = 0;
  logic [23:0] loc_pool[4];
  logic [15:0] len_pool[4];
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles    = 0;
  int          mismatches     = 0;
  int          cycles         = 0;

  register_write_log_encoder #(
    .BOOK_DEPTH(LOG_BOOK_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("register_write_log_encoder_tb NOT OK");
      $finish;
    end
  end

  // hold off for a counted stretch, else stall at random
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (stream_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: byte with none predicted: expected none, actual %h last %b",
                   $time, m_tdata, m_tlast);
      end else begin
        oldest_byte = stream_bytes.pop_front();
        if (m_tdata !== oldest_byte.data || m_tlast !== oldest_byte.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: byte mismatch: expected %h last %b, actual %h last %b",
                     $time, oldest_byte.data, oldest_byte.last, m_tdata, m_tlast);
        end
      end
    end
  end

  function automatic void add_byte(input logic [7:0] b);
    item_bytes.insert(item_bytes.size(), b);
  endfunction

  task automatic encode_item(input logic [1:0] cmd, input logic [9:0] addr,
                             input logic [23:0] val);
    logic [15:0] span;
    logic [15:0] len;
    logic [9:0]  diff;
    int          idx;
    int          i;
    item_bytes.delete();
    if (cmd == CMD_TICK) begin
      if (ticks_owed < WAIT_SAT) ticks_owed++;
    end else if (cmd == CMD_WRITE || cmd == CMD_END) begin
      span = ticks_owed - 16'd1;
      if (ticks_owed == 16'd1) begin
        add_byte(BYTE_WAIT1);
      end else if (ticks_owed >= 16'd2 && ticks_owed < 16'd256) begin
        add_byte(BYTE_WAIT8);
        add_byte(span[7:0]);
      end else if (ticks_owed >= 16'd256 && ticks_owed < WAIT_SAT) begin
        add_byte(BYTE_WAIT16);
        add_byte(span[15:8]);
        add_byte(span[7:0]);
      end
      ticks_owed = '0;
      if (cmd == CMD_END) begin
        add_byte(BYTE_END);
      end else if (addr >= ADDR_SAMPLE) begin
        if (addr[2]) begin
          len = val[15:0];
          idx = -1;
          for (i = 0; i < book_fill && idx < 0; i++)
            if (book_addr[i] == sample_addr && book_size[i] == len) idx = i;
          if (idx < 0 && book_fill < LOG_BOOK_DEPTH) begin
            book_addr[book_fill] = sample_addr;
            book_size[book_fill] = len;
            idx = book_fill;
            book_fill++;
          end
          if (idx >= 0) begin
            add_byte({2'b00, addr[1:0], BOOK_HIT});
            add_byte(idx[7:0]);
          end else begin
            add_byte({2'b00, addr[1:0], BOOK_LIT});
            add_byte(sample_addr[23:16]);
            add_byte(sample_addr[15:8]);
            add_byte(sample_addr[7:0]);
            add_byte(len[15:8]);
            add_byte(len[7:0]);
          end
        end else begin
          sample_addr = val;
        end
      end else if (addr < ADDR_MID) begin
        if (addr[3:0] != LO_DROP_LOW) begin
          add_byte(BYTE_LOW_CMD | {4'h0, addr[3:0]});
          add_byte(val[15:8]);
          add_byte(val[7:0]);
        end
      end else if (addr[3:0] != LO_DROP_MID0 && addr[3:0] != LO_DROP_MID2 &&
                   addr[3:0] != LO_DROP_MID4) begin
        diff = addr - ADDR_MID;
        add_byte(diff[7:0]);
        if (addr[3:0] == LO_BYTE_ONE) begin
          add_byte(val[7:0]);
        end else begin
          add_byte(val[15:8]);
          add_byte(val[7:0]);
        end
      end
    end
    for (i = 0; i < item_bytes.size(); i++)
      stream_bytes.insert(stream_bytes.size(),
                          cmd_byte_t'{data: item_bytes[i],
                                      last: (i == item_bytes.size() - 1)});
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic [9:0] addr,
                           input logic [23:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(IN_TDATA_W - 34){1'b0}}, val, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    encode_item(cmd, addr, val);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(CMD_TICK, 10'($urandom), 24'($urandom));
  endtask

  function automatic logic [9:0] location_reg();
    return {1'b1, 6'($urandom), 1'b0, 2'($urandom)};
  endfunction

  function automatic logic [9:0] length_reg();
    return {1'b1, 6'($urandom), 1'b1, 2'($urandom)};
  endfunction

  task automatic test_wait_encoding();
    send_item(CMD_END, 10'h3FF, 24'hFFFFFF);
    send_ticks(1);
    send_item(CMD_END, 10'h000, 24'h000000);
    send_ticks(2);
    send_item(CMD_WRITE, 10'h000, 24'h000000);
    send_ticks(255);
    send_item(CMD_WRITE, 10'h09F, 24'hFFFFFF);
    send_ticks(256);
    send_item(CMD_WRITE, 10'h0A1, 24'h00A55A);
    send_ticks(5);
    send_item(CMD_WRITE, 10'h200, 24'h123456);
  endtask

  task automatic test_range_writes();
    send_ticks(3);
    send_item(CMD_WRITE, 10'h00A, 24'hFFFFFF);
    send_item(CMD_WRITE, 10'h0A0, 24'h00FFFF);
    send_item(CMD_WRITE, 10'h1F2, 24'h00FFFF);
    send_item(CMD_WRITE, 10'h1F4, 24'h00FFFF);
    send_item(CMD_WRITE, 10'h1F8, 24'hFFFF81);
    send_item(CMD_WRITE, 10'h1FF, 24'h7E1234);
  endtask

  task automatic test_sample_book();
    send_item(CMD_WRITE, 10'h200, 24'hFFFFFF);
    send_item(CMD_WRITE, 10'h207, 24'h00FFFF);
    send_item(CMD_WRITE, 10'h205, 24'hFFFFFF);
    send_item(CMD_WRITE, 10'h3FB, 24'h000000);
    send_item(CMD_WRITE, 10'h3FC, 24'h000000);
  endtask

  task automatic test_undefined_cmd();
    send_ticks(2);
    send_item(2'b11, 10'h3FF, 24'hFFFFFF);
    send_item(CMD_END, 10'h000, 24'h000000);
  endtask

  task automatic test_saturated_wait();
    send_ticks(32767);
    send_item(CMD_END, 10'h000, 24'h000000);
    send_ticks(32768);
    send_item(CMD_END, 10'h000, 24'h000000);
    send_ticks(32800);
    send_item(CMD_WRITE, 10'h003, 24'h00BEEF);
  endtask

  task automatic test_random_mix(input int count, input int idle_pct, input int stall_pct);
    int          n;
    int          pick;
    logic [15:0] len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        if ($urandom_range(9) == 0) send_ticks($urandom_range(300));
        else send_ticks($urandom_range(4));
      end else if (pick < 40) begin
        send_item(CMD_WRITE, location_reg(),
                  ($urandom_range(3) == 0) ? 24'($urandom) : loc_pool[$urandom_range(3)]);
      end else if (pick < 60) begin
        len = ($urandom_range(3) == 0) ? 16'($urandom) : len_pool[$urandom_range(3)];
        send_item(CMD_WRITE, length_reg(), {8'($urandom), len});
      end else if (pick < 75) begin
        send_item(CMD_WRITE, 10'($urandom_range(ADDR_MID - 1)), 24'($urandom));
      end else if (pick < 88) begin
        send_item(CMD_WRITE, 10'($urandom_range(ADDR_MID, ADDR_SAMPLE - 1)), 24'($urandom));
      end else if (pick < 94) begin
        send_item(CMD_END, 10'($urandom), 24'($urandom));
      end else begin
        send_item(2'($urandom), 10'($urandom), 24'($urandom));
      end
    end
  endtask

  task automatic test_back_pressure();
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_cycles = 400;
    for (k = 0; k < 12; k++)
      send_item(CMD_WRITE, 10'($urandom_range(ADDR_MID - 1)), 24'($urandom));
  endtask

  task automatic test_book_fill();
    logic [23:0] first_loc;
    logic [23:0] last_loc;
    logic [15:0] first_len;
    logic [15:0] last_len;
    logic [15:0] len;
    int          k;
    send_idle_pct  = 0;
    recv_stall_pct = 60;
    first_loc = book_addr[0];
    first_len = book_size[0];
    last_loc  = sample_addr;
    last_len  = '0;
    while (book_fill < LOG_BOOK_DEPTH) begin
      if ($urandom_range(3) == 0) begin
        last_loc = 24'($urandom);
        send_item(CMD_WRITE, location_reg(), last_loc);
      end
      len = 16'($urandom);
      last_loc = sample_addr;
      last_len = len;
      send_item(CMD_WRITE, length_reg(), {8'($urandom), len});
    end
    for (k = 0; k < 4; k++) begin
      send_item(CMD_WRITE, location_reg(), 24'($urandom));
      send_item(CMD_WRITE, length_reg(), 24'($urandom));
    end
    send_item(CMD_WRITE, location_reg(), first_loc);
    send_item(CMD_WRITE, length_reg(), {8'hA5, first_len});
    send_item(CMD_WRITE, location_reg(), last_loc);
    send_item(CMD_WRITE, length_reg(), {8'h5A, last_len});
  endtask

  initial begin
    loc_pool[0] = 24'h000000;
    loc_pool[1] = 24'hFFFFFF;
    loc_pool[2] = 24'($urandom);
    loc_pool[3] = 24'($urandom);
    len_pool[0] = 16'h0000;
    len_pool[1] = 16'hFFFF;
    len_pool[2] = 16'($urandom);
    len_pool[3] = 16'($urandom);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_wait_encoding();
    test_range_writes();
    test_sample_book();
    test_undefined_cmd();
    test_saturated_wait();
    test_random_mix(65, 0, 0);
    test_random_mix(65, 60, 0);
    test_back_pressure();
    test_book_fill();
    test_random_mix(65, 0, 60);
    test_random_mix(65, 38, 38);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (stream_bytes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("register_write_log_encoder_tb OK");
    end else begin
      $display("register_write_log_encoder_tb NOT OK");
    end
    $finish;
  end

endmodule
